// File: hdl/blee_pkg.sv
// ---------------------------------------------------------------------------
// blee_pkg
// Shared types, request codes and status codes for the list edit engine.
// ---------------------------------------------------------------------------
package blee_pkg;

   localparam int CAPACITY_DEF = 16;

   typedef enum logic [2:0] {
      OP_INSERT     = 3'd0,
      OP_REMOVE_ONE = 3'd1,
      OP_REMOVE_ALL = 3'd2,
      OP_REVERSE    = 3'd3,
      OP_CLASSIFY   = 3'd4,
      OP_READ       = 3'd5
   } op_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;

   localparam logic [1:0] ORD_NONE = 2'd0;
   localparam logic [1:0] ORD_UP   = 2'd1;
   localparam logic [1:0] ORD_DOWN = 2'd2;
   localparam logic [1:0] ORD_FLAT = 2'd3;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [4:0]        position;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [4:0]         entry_count;
      logic [4:0]         removed_count;
      logic [1:0]         order_class;
      logic signed [31:0] read_value;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic ins_wr;
      logic rd_lo;
      logic rd_hi;
      logic wr_lo;
      logic wr_hi;
      logic rd_idx;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       err;
      logic       scan_done;
      logic       rev_more;
      logic       rev_next;
      logic       rsp_free;
   } stat_type;

endpackage

// File: hdl/blee_datapath.sv
// ---------------------------------------------------------------------------
// blee_datapath
// Entry memory, count, pointers and result register of the list engine.
// ---------------------------------------------------------------------------
module blee_datapath #(
   parameter int CAPACITY = blee_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  blee_pkg::req_payload_type req_payload,
   input  blee_pkg::cmd_type         cmd,
   output blee_pkg::stat_type        stat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output blee_pkg::rsp_payload_type rsp_payload
);
   import blee_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int XW = (CW > 5) ? CW : 5;

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] mem_q_ff;
   logic signed [31:0] tmp_ff;

   logic [2:0]         op_ff;
   logic signed [31:0] val_ff;
   logic [2:0]         st_ff, st_in;
   logic [CW-1:0]      cnt_ff, cnt_in, i_ff, i_in, w_ff, w_in, slot_ff, slot_in;
   logic [CW-1:0]      pidx_ff, pidx_in, rem_ff, rem_in;
   logic               pend_ff, pend_in;
   logic               up_ff, up_in, down_ff, down_in, flat_ff, flat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] wr_data;
   logic               issue, drop;
   logic [XW-1:0]      pos_x, cnt_x, slot_x, cnt_fin_x, rem_x;
   logic [CW-1:0]      cnt_fin, cnt_m1, i_m1, pidx_p1;
   logic [CW:0]        i_p2;
   logic [2:0]         st_fin;
   logic [1:0]         ord;

   always_comb begin
      pos_x   = XW'(req_payload.position);
      cnt_x   = XW'(cnt_ff);
      slot_x  = (pos_x == '0) ? '0 : pos_x - XW'(1);
      if (slot_x > cnt_x) begin
         slot_x = cnt_x;
      end
      cnt_m1  = cnt_ff - CW'(1);
      i_m1    = i_ff - CW'(1);
      pidx_p1 = pidx_ff + CW'(1);
      i_p2    = {1'b0, i_ff} + (CW+1)'(2);
      issue   = (op_ff == OP_INSERT) ? (i_ff > slot_ff) : (i_ff < cnt_ff);
      drop    = (mem_q_ff == val_ff) && ((op_ff == OP_REMOVE_ALL) || (rem_ff == '0));

      st_in = st_ff; cnt_in = cnt_ff; i_in = i_ff; w_in = w_ff; slot_in = slot_ff;
      pidx_in = pidx_ff; rem_in = rem_ff; pend_in = 1'b0;
      up_in = up_ff; down_in = down_ff; flat_in = flat_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = mem_q_ff;

      if (cmd.start) begin
         st_in   = ST_OK;
         slot_in = CW'(slot_x);
         rem_in  = '0;
         up_in   = 1'b1; down_in = 1'b1; flat_in = 1'b1;
         i_in    = (req_payload.req_type == OP_INSERT) ? cnt_ff : '0;
         w_in    = (req_payload.req_type == OP_REVERSE) ? cnt_m1 : '0;
         unique case (req_payload.req_type) inside
            OP_INSERT: begin
               if (cnt_ff == CW'(CAPACITY)) st_in = ST_FULL;
            end
            OP_REMOVE_ONE, OP_REMOVE_ALL, OP_REVERSE, OP_CLASSIFY: begin
               if (cnt_ff == '0) st_in = ST_EMPTY;
            end
            OP_READ: begin
               if (pos_x == '0 || pos_x > cnt_x) st_in = ST_BAD_INDEX;
            end
            default: st_in = ST_OK;
         endcase
      end

      if (cmd.scan) begin
         pend_in = issue;
         if (issue) begin
            rd_en = 1'b1;
            if (op_ff == OP_INSERT) begin
               rd_addr = i_m1[AW-1:0]; pidx_in = i_m1; i_in = i_m1;
            end else begin
               rd_addr = i_ff[AW-1:0]; pidx_in = i_ff; i_in = i_ff + CW'(1);
            end
         end
         if (pend_ff) begin
            if (op_ff == OP_INSERT) begin
               wr_en = 1'b1; wr_addr = pidx_p1[AW-1:0];
            end else if (op_ff == OP_CLASSIFY) begin
               if (pidx_ff != '0) begin
                  if (tmp_ff != mem_q_ff) flat_in = 1'b0;
                  if (mem_q_ff < tmp_ff) up_in = 1'b0;
                  if (tmp_ff < mem_q_ff) down_in = 1'b0;
               end
            end else if (drop) begin
               rem_in = rem_ff + CW'(1);
            end else begin
               wr_en = 1'b1; wr_addr = w_ff[AW-1:0]; w_in = w_ff + CW'(1);
            end
         end
      end

      if (cmd.ins_wr) begin
         wr_en = 1'b1; wr_addr = slot_ff[AW-1:0]; wr_data = val_ff;
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.rd_lo) begin
         rd_en = 1'b1; rd_addr = i_ff[AW-1:0];
      end
      if (cmd.rd_hi) begin
         rd_en = 1'b1; rd_addr = w_ff[AW-1:0];
      end
      if (cmd.wr_lo) begin
         wr_en = 1'b1; wr_addr = i_ff[AW-1:0];
      end
      if (cmd.wr_hi) begin
         wr_en = 1'b1; wr_addr = w_ff[AW-1:0]; wr_data = tmp_ff;
         i_in = i_ff + CW'(1); w_in = w_ff - CW'(1);
      end
      if (cmd.rd_idx) begin
         rd_en = 1'b1; rd_addr = slot_ff[AW-1:0];
      end

      cnt_fin = ((op_ff == OP_REMOVE_ONE || op_ff == OP_REMOVE_ALL) && st_ff == ST_OK)
                ? w_ff : cnt_ff;
      st_fin  = st_ff;
      if ((op_ff == OP_REMOVE_ONE || op_ff == OP_REMOVE_ALL) && st_ff == ST_OK
          && rem_ff == '0) begin
         st_fin = ST_NOT_FOUND;
      end
      if (flat_ff)      ord = ORD_FLAT;
      else if (up_ff)   ord = ORD_UP;
      else if (down_ff) ord = ORD_DOWN;
      else              ord = ORD_NONE;
      cnt_fin_x = XW'(cnt_fin);
      rem_x     = XW'(rem_ff);

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         cnt_in               = cnt_fin;
         rsp_valid_in         = 1'b1;
         rsp_in.status        = st_fin;
         rsp_in.entry_count   = cnt_fin_x[4:0];
         rsp_in.removed_count = rem_x[4:0];
         rsp_in.order_class   = (op_ff == OP_CLASSIFY) ? ord : ORD_NONE;
         rsp_in.read_value    = (op_ff == OP_READ && st_ff == ST_OK) ? mem_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) mem_q_ff <= mem[rd_addr];
      if (cmd.rd_hi) tmp_ff <= mem_q_ff;
      else if (cmd.scan && pend_ff) tmp_ff <= mem_q_ff;
      if (req_fire) begin
         op_ff  <= req_payload.req_type;
         val_ff <= req_payload.value;
      end
      st_ff <= st_in; i_ff <= i_in; w_ff <= w_in; pidx_ff <= pidx_in; rem_ff <= rem_in;
      slot_ff <= (cmd.start && req_payload.req_type == OP_READ)
                 ? CW'(slot_x) : slot_in;
      up_ff <= up_in; down_ff <= down_in; flat_ff <= flat_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.op        = op_ff;
   assign stat.err       = (st_ff != ST_OK);
   assign stat.scan_done = !issue && !pend_ff;
   assign stat.rev_more  = (i_ff < w_ff);
   assign stat.rev_next  = (i_p2 < {1'b0, w_ff});
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_payload    = rsp_ff;

endmodule

// File: hdl/blee_control.sv
// ---------------------------------------------------------------------------
// blee_control
// Sequencer that steps the datapath through each request.
// ---------------------------------------------------------------------------
module blee_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  blee_pkg::stat_type stat,
   output blee_pkg::cmd_type  cmd
);
   import blee_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_DISPATCH = 10'b0000000010,
      S_SCAN     = 10'b0000000100,
      S_INS_WR   = 10'b0000001000,
      S_REV_RDLO = 10'b0000010000,
      S_REV_RDHI = 10'b0000100000,
      S_REV_WRLO = 10'b0001000000,
      S_REV_WRHI = 10'b0010000000,
      S_RD_IDX   = 10'b0100000000,
      S_FINISH   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.err) begin
               state_in = S_FINISH;
            end else begin
               case (stat.op) inside
                  OP_INSERT, OP_REMOVE_ONE, OP_REMOVE_ALL, OP_CLASSIFY: state_in = S_SCAN;
                  OP_REVERSE: state_in = stat.rev_more ? S_REV_RDLO : S_FINISH;
                  OP_READ:    state_in = S_RD_IDX;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = (stat.op == OP_INSERT) ? S_INS_WR : S_FINISH;
            end
         end
         S_INS_WR: begin
            cmd.ins_wr = 1'b1;
            state_in   = S_FINISH;
         end
         S_REV_RDLO: begin
            cmd.rd_lo = 1'b1;
            state_in  = S_REV_RDHI;
         end
         S_REV_RDHI: begin
            cmd.rd_hi = 1'b1;
            state_in  = S_REV_WRLO;
         end
         S_REV_WRLO: begin
            cmd.wr_lo = 1'b1;
            state_in  = S_REV_WRHI;
         end
         S_REV_WRHI: begin
            cmd.wr_hi = 1'b1;
            state_in  = stat.rev_next ? S_REV_RDLO : S_FINISH;
         end
         S_RD_IDX: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: hdl/bounded_list_edit_engine_core.sv
// ---------------------------------------------------------------------------
// bounded_list_edit_engine_core
// Ordered list of signed 32-bit values with insert, remove, reverse,
// order classification and indexed read.
// ---------------------------------------------------------------------------
// Steps: idle, dispatch, finish for all; error cases and unused codes go
// straight to finish. Insert scans then writes its slot, removes and classify
// scan, read reads its slot, reverse swaps pairs (one memory read port, one write port).
// Throughput: one request at a time; the next is taken once the previous
// one has reached the response register.
// Reset: count and control cleared; entry memory is not cleared.
module bounded_list_edit_engine_core #(
   parameter int CAPACITY = blee_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  blee_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output blee_pkg::rsp_payload_type rsp_payload
);
   import blee_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   blee_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   blee_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (cmd.start),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/blee_checker.sv
// ---------------------------------------------------------------------------
// blee_checker
// Port-level assertions for the list edit engine, bound to the top level.
// ---------------------------------------------------------------------------
module blee_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input blee_pkg::rsp_payload_type rsp_payload
);
   import blee_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready straight after acceptance");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.read_value != '0 |-> rsp_payload.status == ST_OK
      && rsp_payload.order_class == ORD_NONE && rsp_payload.removed_count == '0)
      else $error("read data on a non-read response");

   a_err_noremove: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL || rsp_payload.status == ST_EMPTY
      || rsp_payload.status == ST_NOT_FOUND) |-> rsp_payload.removed_count == '0)
      else $error("removal reported with an error status");

endmodule

bind bounded_list_edit_engine_core blee_checker u_blee_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
